### rtl/core/sls_pkg.sv
`timescale 1ns / 1ps

package sls_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int POS_FIELD_W      = 6;
    localparam int COUNT_FIELD_W    = 7;
    localparam int CHUNK_W          = 8;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_FIND   = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_RANGE  = 2'd1;
    localparam status_t ST_FULL   = 2'd2;
    localparam status_t ST_ABSENT = 2'd3;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
    } find_res_t;

endpackage

### rtl/core/sequential_list_store.sv
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                        | tuser
// s_      | in  | position[5:0], value[37:6], zero pad       | operation[1:0]
// m_      | out | found_position[5:0], entry_count[12:6],    | status[1:0]
//         |     | is_empty[13], zero pad                     |
//
// insert, delete and clear finish in the cycle the item is taken; the result
// is held in an output register. for find, the cell row compares all entries at
// once, then the match row is scanned eight cells per cycle until the first
// match or the last chunk. reset clears the count and the control state, not
// the entries. a stalled result blocks new items until it is taken.

module sequential_list_store #(
    parameter int CAPACITY = sls_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position, value, pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // found_position, entry_count, is_empty, pad
    output logic [1:0]  m_tuser    // status
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > sls_pkg::POS_FIELD_W) ? CW : sls_pkg::POS_FIELD_W;
    localparam int NCH = (CAPACITY + sls_pkg::CHUNK_W - 1) / sls_pkg::CHUNK_W;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int FPW = CHW + 3;
    localparam int VW  = NCH * sls_pkg::CHUNK_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIND = 1'b1;

    logic                         state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         m_valid_reg, m_valid_next;
    sls_pkg::status_t             status_reg, status_next;
    logic [sls_pkg::POS_FIELD_W-1:0]   fpos_reg, fpos_next;
    logic [sls_pkg::COUNT_FIELD_W-1:0] cnt_out_reg, cnt_out_next;
    logic                         empty_reg, empty_next;

    sls_pkg::op_t                 op;
    logic [sls_pkg::POS_FIELD_W-1:0] in_pos;
    logic [sls_pkg::VALUE_W-1:0]  in_value;
    logic [PW-1:0]                pos_x;
    logic [PW-1:0]                count_x;
    logic                         accept;
    sls_pkg::cell_cmd_t           cmd;
    logic                         ins_ok, del_ok;
    sls_pkg::status_t             acc_status;

    logic [sls_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
    logic [VW-1:0]                match_vec;
    sls_pkg::find_res_t           find_res;
    logic [FPW-1:0]               find_pos;
    logic [FPW+sls_pkg::POS_FIELD_W-1:0] find_pos_ext;
    logic [CW+sls_pkg::COUNT_FIELD_W-1:0] count_ext;

    assign op       = s_tuser;
    assign in_pos   = s_tdata[5:0];
    assign in_value = s_tdata[37:6];
    assign pos_x    = PW'(in_pos);
    assign count_x  = PW'(count_reg);

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        acc_status = sls_pkg::ST_OK;
        count_next = count_reg;
        unique case (op)
            sls_pkg::OP_INSERT: begin
                if (pos_x > count_x || pos_x >= CAP_P) begin
                    acc_status = sls_pkg::ST_RANGE;
                end else if (count_reg >= CAP_C) begin
                    acc_status = sls_pkg::ST_FULL;
                end else begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            sls_pkg::OP_DELETE: begin
                if (pos_x >= count_x) begin
                    acc_status = sls_pkg::ST_RANGE;
                end else begin
                    del_ok     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            sls_pkg::OP_FIND: begin
                acc_status = sls_pkg::ST_ABSENT;
            end
            sls_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                acc_status = sls_pkg::ST_OK;
            end
        endcase
        if (!accept) begin
            count_next = count_reg;
        end
    end

    assign cmd.ins   = accept && ins_ok;
    assign cmd.del   = accept && del_ok;
    assign cmd.value = in_value;

    // row of entry cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sls_cell #(
            .INDEX (i),
            .PW    (PW),
            .CW    (CW)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .pos       (pos_x),
            .count     (count_reg),
            .prev_data (cell_data[(i == 0) ? 0 : i - 1]),
            .next_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .data      (cell_data[i]),
            .match     (match_vec[i])
        );
    end

    if (VW > CAPACITY) begin : g_pad
        assign match_vec[VW-1:CAPACITY] = '0;
    end

    sls_find #(
        .NCH (NCH),
        .FPW (FPW)
    ) u_find (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && op == sls_pkg::OP_FIND),
        .match_vec (match_vec),
        .res       (find_res),
        .pos       (find_pos)
    );

    assign find_pos_ext = {{sls_pkg::POS_FIELD_W{1'b0}}, find_pos};
    assign count_ext    = {{sls_pkg::COUNT_FIELD_W{1'b0}}, count_next};

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        fpos_next    = fpos_reg;
        cnt_out_next = cnt_out_reg;
        empty_next   = empty_reg;
        if (accept) begin
            if (op == sls_pkg::OP_FIND) begin
                state_next = ST_FIND;
            end else begin
                m_valid_next = 1'b1;
                status_next  = acc_status;
                fpos_next    = '0;
                cnt_out_next = count_ext[sls_pkg::COUNT_FIELD_W-1:0];
                empty_next   = (count_next == '0);
            end
        end else if (state_reg == ST_FIND && find_res.done) begin
            state_next   = ST_IDLE;
            m_valid_next = 1'b1;
            status_next  = find_res.found ? sls_pkg::ST_OK : sls_pkg::ST_ABSENT;
            fpos_next    = find_res.found ? find_pos_ext[sls_pkg::POS_FIELD_W-1:0] : '0;
            cnt_out_next = count_ext[sls_pkg::COUNT_FIELD_W-1:0];
            empty_next   = (count_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg  <= status_next;
        fpos_reg    <= fpos_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, empty_reg, cnt_out_reg, fpos_reg};

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIND |-> !s_tready)
        else $error("item taken during find scan");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == sls_pkg::OP_CLEAR) |=> (count_reg == '0 && m_tvalid))
        else $error("clear did not empty the list");

    a_find_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIND && find_res.done) |=> (state_reg == ST_IDLE && m_tvalid))
        else $error("find result not delivered");

endmodule

### rtl/core/sls_cell.sv
`timescale 1ns / 1ps

module sls_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 7,
    parameter int CW    = 7
) (
    input  logic                       aclk,
    input  sls_pkg::cell_cmd_t         cmd,
    input  logic [PW-1:0]              pos,
    input  logic [CW-1:0]              count,
    input  logic [sls_pkg::VALUE_W-1:0] prev_data,
    input  logic [sls_pkg::VALUE_W-1:0] next_data,
    output logic [sls_pkg::VALUE_W-1:0] data,
    output logic                       match
);

    localparam logic [PW-1:0] IDX_P = PW'(INDEX);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic [sls_pkg::VALUE_W-1:0] data_reg;
    logic [sls_pkg::VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (IDX_P > pos) begin
                data_next = prev_data;
            end else if (IDX_P == pos) begin
                data_next = cmd.value;
            end
        end else if (cmd.del && IDX_P >= pos) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == cmd.value) && (IDX_C < count);

endmodule

### rtl/core/sls_find.sv
`timescale 1ns / 1ps

module sls_find #(
    parameter int NCH = 8,
    parameter int FPW = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [NCH*sls_pkg::CHUNK_W-1:0]    match_vec,
    output sls_pkg::find_res_t                 res,
    output logic [FPW-1:0]                     pos
);

    localparam int VW  = NCH * sls_pkg::CHUNK_W;
    localparam int CHW = FPW - 3;
    localparam logic [CHW-1:0] LAST_CH = CHW'(NCH - 1);

    logic [VW-1:0]  vec_reg;
    logic [VW-1:0]  vec_next;
    logic [CHW-1:0] ch_reg;
    logic [CHW-1:0] ch_next;
    logic           busy_reg;
    logic           busy_next;
    logic [2:0]     enc;
    logic           any;
    logic [sls_pkg::CHUNK_W-1:0] low;

    assign low = vec_reg[sls_pkg::CHUNK_W-1:0];
    assign any = |low;

    always_comb begin
        enc = 3'd0;
        for (int k = sls_pkg::CHUNK_W - 1; k >= 0; k--) begin
            if (low[k]) begin
                enc = 3'(k);
            end
        end
    end

    assign res.done  = busy_reg && (any || ch_reg == LAST_CH);
    assign res.found = any;
    assign pos       = {ch_reg, enc};

    always_comb begin
        vec_next  = vec_reg;
        ch_next   = ch_reg;
        busy_next = busy_reg;
        if (start) begin
            vec_next  = match_vec;
            ch_next   = '0;
            busy_next = 1'b1;
        end else if (res.done) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            vec_next = vec_reg >> sls_pkg::CHUNK_W;
            ch_next  = ch_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        vec_reg <= vec_next;
        ch_reg  <= ch_next;
    end

endmodule

### tb/tb_sequential_list_store.sv
`timescale 1ns / 1ps

module tb_sequential_list_store;

    localparam int LIST_CAP      = sls_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int BLOCK_ITEMS   = 100;
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_HOLD = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        sls_pkg::op_t op;
        logic [5:0]   pos;
        logic [31:0]  val;
    } list_req_t;

    typedef struct {
        sls_pkg::status_t status;
        logic [5:0]       found_position;
        logic [6:0]       entry_count;
        logic             is_empty;
    } list_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    sequential_list_store i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow of the list contents, updated on every accepted item
    logic [31:0] shadow_entries [LIST_CAP];
    int          shadow_len = 0;
    int          peak_len   = 0;
    int          op_seen     [4];
    int          status_seen [4];

    list_req_t   pending_requests [$];
    list_reply_t expected_replies [$];

    logic [31:0] value_pool [12];
    int          plan_len = 0;

    list_req_t   next_req;
    list_reply_t want;
    int          idle_left     = 0;
    int          stall_left    = 0;
    int          req_sent      = 0;
    int          results_seen  = 0;
    bit          pressure_done = 1'b0;
    int          errors        = 0;
    int          idle_cycles   = 0;
    int          stall;

    task automatic apply_list_request(input sls_pkg::op_t op, input logic [5:0] pos,
                                      input logic [31:0] val);
        list_reply_t r;
        int i;
        r.status         = sls_pkg::ST_OK;
        r.found_position = '0;
        case (op)
            sls_pkg::OP_INSERT: begin
                if (int'(pos) > shadow_len || int'(pos) >= LIST_CAP) begin
                    r.status = sls_pkg::ST_RANGE;
                end else if (shadow_len >= LIST_CAP) begin
                    r.status = sls_pkg::ST_FULL;
                end else begin
                    for (i = shadow_len; i > int'(pos); i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = val;
                    shadow_len++;
                end
            end
            sls_pkg::OP_DELETE: begin
                if (int'(pos) >= shadow_len) begin
                    r.status = sls_pkg::ST_RANGE;
                end else begin
                    shadow_len--;
                    for (i = int'(pos); i < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                end
            end
            sls_pkg::OP_FIND: begin
                r.status = sls_pkg::ST_ABSENT;
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_entries[i] == val) begin
                        r.status         = sls_pkg::ST_OK;
                        r.found_position = i[5:0];
                        break;
                    end
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.entry_count = shadow_len[6:0];
        r.is_empty    = (shadow_len == 0);
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        op_seen[op]++;
        status_seen[r.status]++;
        expected_replies.push_back(r);
    endtask

    // queue an item and track the length it will leave behind
    task automatic plan_request(input sls_pkg::op_t op, input logic [5:0] pos,
                                input logic [31:0] val);
        list_req_t q;
        q.op  = op;
        q.pos = pos;
        q.val = val;
        pending_requests.push_back(q);
        case (op)
            sls_pkg::OP_INSERT: if (int'(pos) <= plan_len && plan_len < LIST_CAP) plan_len++;
            sls_pkg::OP_DELETE: if (int'(pos) < plan_len) plan_len--;
            sls_pkg::OP_CLEAR:  plan_len = 0;
            default:            ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            idle_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_list_request(sls_pkg::op_t'(s_tuser), s_tdata[5:0], s_tdata[37:6]);
                req_sent <= req_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, next_req.val, next_req.pos};
                    s_tuser  <= next_req.op;
                    idle_left <= ((req_sent / 150) % 4 == 2) ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_replies.size() == 0) begin
                    $error("result item with no request outstanding");
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[5:0] !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, m_tdata[5:0]);
                        errors++;
                    end
                    if (m_tdata[12:6] !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_tdata[12:6]);
                        errors++;
                    end
                    if (m_tdata[13] !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d",
                               want.is_empty, m_tdata[13]);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
                // long hold-off so the block backs up into its input
                pressure_done <= 1'b1;
                stall_left    <= PRESSURE_HOLD;
                m_tready      <= 1'b0;
            end else if ((results_seen / 150) % 4 == 1) begin
                m_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left <= stall - 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int r;
        int mode;
        int ins_pct;
        int del_pct;
        int find_pct;
        logic [5:0] pos;

        value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                       32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_00FF, 32'hFF00_0000};

        // directed: empty-list errors, extremes, duplicates, shifts, clear
        plan_request(sls_pkg::OP_DELETE, 6'd0,  32'h0);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'h0);
        plan_request(sls_pkg::OP_INSERT, 6'd1,  32'h1);
        plan_request(sls_pkg::OP_INSERT, 6'd63, 32'hFFFF_FFFF);
        plan_request(sls_pkg::OP_INSERT, 6'd0,  32'h8000_0000);
        plan_request(sls_pkg::OP_INSERT, 6'd1,  32'h7FFF_FFFF);
        plan_request(sls_pkg::OP_INSERT, 6'd1,  32'h0000_0000);
        plan_request(sls_pkg::OP_INSERT, 6'd0,  32'hFFFF_FFFF);
        plan_request(sls_pkg::OP_INSERT, 6'd0,  32'h7FFF_FFFF);
        plan_request(sls_pkg::OP_FIND,   6'd63, 32'h7FFF_FFFF);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'h0000_0000);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'h0000_3039);
        plan_request(sls_pkg::OP_DELETE, 6'd5,  32'h0);
        plan_request(sls_pkg::OP_DELETE, 6'd4,  32'h0);
        plan_request(sls_pkg::OP_DELETE, 6'd0,  32'h0);
        plan_request(sls_pkg::OP_DELETE, 6'd1,  32'h0);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'h8000_0000);
        plan_request(sls_pkg::OP_CLEAR,  6'd63, 32'hFFFF_FFFF);
        plan_request(sls_pkg::OP_CLEAR,  6'd0,  32'h0);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'h0000_0000);
        plan_request(sls_pkg::OP_INSERT, 6'd0,  32'h5555_5555);
        plan_request(sls_pkg::OP_FIND,   6'd0,  32'hAAAA_AAAA);
        plan_request(sls_pkg::OP_DELETE, 6'd63, 32'h0);

        // random: blocks that grow, shrink or mix, mostly valid positions
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0)
                mode = (n < 2 * BLOCK_ITEMS) ? 0 : $urandom_range(0, 2);
            case (mode)
                0:       begin ins_pct = 70; del_pct = 80; find_pct = 99; end
                1:       begin ins_pct = 15; del_pct = 80; find_pct = 99; end
                default: begin ins_pct = 35; del_pct = 65; find_pct = 98; end
            endcase
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                if ($urandom_range(0, 9) == 0)
                    pos = 6'($urandom_range(0, 63));
                else
                    pos = (plan_len >= LIST_CAP) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, plan_len));
                plan_request(sls_pkg::OP_INSERT, pos, pick_value(60));
            end else if (r < del_pct) begin
                if ($urandom_range(0, 9) == 0 || plan_len == 0)
                    pos = 6'($urandom_range(0, 63));
                else
                    pos = 6'($urandom_range(0, plan_len - 1));
                plan_request(sls_pkg::OP_DELETE, pos, $urandom);
            end else if (r < find_pct) begin
                plan_request(sls_pkg::OP_FIND, 6'($urandom_range(0, 63)), pick_value(70));
            end else begin
                plan_request(sls_pkg::OP_CLEAR, 6'($urandom_range(0, 63)), $urandom);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (pending_requests.size() != 0 || s_tvalid);
        while (expected_replies.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items: %0d inserts, %0d deletes, %0d finds, %0d clears",
                 req_sent, op_seen[sls_pkg::OP_INSERT], op_seen[sls_pkg::OP_DELETE],
                 op_seen[sls_pkg::OP_FIND], op_seen[sls_pkg::OP_CLEAR]);
        $display("peak length %0d; status: %0d ok, %0d bad position, %0d full, %0d not found",
                 peak_len, status_seen[sls_pkg::ST_OK], status_seen[sls_pkg::ST_RANGE],
                 status_seen[sls_pkg::ST_FULL], status_seen[sls_pkg::ST_ABSENT]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/sls_pkg.sv
rtl/core/sls_cell.sv
rtl/core/sls_find.sv
rtl/core/sequential_list_store.sv
tb/tb_sequential_list_store.sv
